FILE: sv/sdsk_pkg.sv
// ----------------------------------------------------------------------------
// sdsk_pkg
// Shared types and constants for the two-stacks-in-one-array block.
// ----------------------------------------------------------------------------
package sdsk_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic SIDE_LOW  = 1'b0;
   localparam logic SIDE_HIGH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;       // A request beat is taken this cycle.
      logic load_direct;  // Result needs no store read; load it now.
      logic load_mem;     // Store read data is ready; load the result.
   } sdsk_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_read;   // Current request returns words from the store.
   } sdsk_stat_type;

endpackage

FILE: sv/shared_array_dual_stack.sv
// ----------------------------------------------------------------------------
// shared_array_dual_stack
// Two stacks sharing one store; the low stack grows up, the high one down.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one command beat carries cmd (push, pop, peek),
//   side (low or high stack) and value (the word to push).
//   Response channel (rsp_*): exactly one beat per request with the status,
//   the popped word, and both tops with valid flags for a peek.
//   A push, an empty pop, an empty peek or an unused command shows its
//   response the cycle after acceptance; a pop or peek that reads the
//   store passes through the store's registered read port and then the
//   response register.
//   Throughput: one push per cycle while responses are taken; a pop or
//   peek that reads the store blocks new requests until its read returns.
//   Reset clears both stack counts, so both stacks start empty; store
//   contents are not cleared and need no clearing pass.
//   When the receiver stalls, the response is held in its output register
//   and no new request is taken until that beat leaves; a new request is
//   taken in the same cycle the waiting beat is accepted.
// ----------------------------------------------------------------------------
module shared_array_dual_stack import sdsk_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic                     req_side,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_popped,
   output logic signed [WORD_W-1:0] rsp_low_top,
   output logic                     rsp_low_valid,
   output logic signed [WORD_W-1:0] rsp_high_top,
   output logic                     rsp_high_valid
);

   sdsk_ctl_type  ctl;
   sdsk_stat_type stat;

   sdsk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .ctl      (ctl)
   );

   sdsk_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_cmd       (req_cmd),
      .req_side      (req_side),
      .req_value     (req_value),
      .rsp_status    (rsp_status),
      .rsp_popped    (rsp_popped),
      .rsp_low_top   (rsp_low_top),
      .rsp_low_valid (rsp_low_valid),
      .rsp_high_top  (rsp_high_top),
      .rsp_high_valid(rsp_high_valid)
   );

endmodule

FILE: sv/sdsk_ram.sv
// ----------------------------------------------------------------------------
// sdsk_ram
// Generic RAM: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module sdsk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: sv/sdsk_ctrl.sv
// ----------------------------------------------------------------------------
// sdsk_ctrl
// Controller: request/response handshake and the store read sequence.
// ----------------------------------------------------------------------------
module sdsk_ctrl import sdsk_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  sdsk_stat_type stat,
   output sdsk_ctl_type  ctl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // The response register must be empty, or emptying now, to take a beat.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      ctl.accept      = accept;
      ctl.load_direct = 1'b0;
      ctl.load_mem    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stat.needs_read) begin
                  state_in = ST_READ;
               end else begin
                  ctl.load_direct = 1'b1;
               end
            end
         end
         ST_READ: begin
            ctl.load_mem = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_direct || ctl.load_mem) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: sv/sdsk_dpath.sv
// ----------------------------------------------------------------------------
// sdsk_dpath
// Datapath: stack counts, store access and the response register.
// ----------------------------------------------------------------------------
module sdsk_dpath import sdsk_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sdsk_ctl_type               ctl,
   output sdsk_stat_type              stat,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic                       req_side,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_popped,
   output logic signed [WORD_W-1:0]   rsp_low_top,
   output logic                       rsp_low_valid,
   output logic signed [WORD_W-1:0]   rsp_high_top,
   output logic                       rsp_high_valid
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [CW-1:0] low_count_ff, low_count_in;
   logic [CW-1:0] high_count_ff, high_count_in;

   logic          low_empty, high_empty, full;
   logic [CW:0]   total;
   logic [CW-1:0] high_push_pos, high_top_pos;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr_a, rd_addr_b;
   logic [WORD_W-1:0] rd_data_a, rd_data_b;

   // Facts about the request in flight, kept for the cycle the read returns.
   logic pend_pop_ff, pend_side_ff, pend_lval_ff, pend_hval_ff;

   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [WORD_W-1:0] popped_ff, popped_in;
   logic signed [WORD_W-1:0] low_top_ff, low_top_in;
   logic signed [WORD_W-1:0] high_top_ff, high_top_in;
   logic                     low_valid_ff, low_valid_in;
   logic                     high_valid_ff, high_valid_in;

   assign low_empty     = (low_count_ff == '0);
   assign high_empty    = (high_count_ff == '0);
   assign total         = {1'b0, low_count_ff} + {1'b0, high_count_ff};
   assign full          = (total >= (CW + 1)'(DEPTH));
   assign high_push_pos = CW'(DEPTH - 1) - high_count_ff;
   assign high_top_pos  = CW'(DEPTH) - high_count_ff;

   // Port A serves the low top, port B the high top; both are always driven.
   assign rd_addr_a = low_count_ff[AW-1:0] - AW'(1);
   assign rd_addr_b = high_top_pos[AW-1:0];

   assign wr_en   = ctl.accept && (req_cmd == CMD_PUSH) && !full;
   assign wr_addr = (req_side == SIDE_LOW) ? low_count_ff[AW-1:0] : high_push_pos[AW-1:0];

   always_comb begin
      stat.needs_read = 1'b0;
      case (req_cmd)
         CMD_POP:  stat.needs_read = (req_side == SIDE_LOW) ? !low_empty : !high_empty;
         CMD_PEEK: stat.needs_read = !low_empty || !high_empty;
         default:  stat.needs_read = 1'b0;
      endcase
   end

   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      if (ctl.accept) begin
         case (req_cmd)
            CMD_PUSH: begin
               if (!full) begin
                  if (req_side == SIDE_LOW) begin
                     low_count_in = low_count_ff + CW'(1);
                  end else begin
                     high_count_in = high_count_ff + CW'(1);
                  end
               end
            end
            CMD_POP: begin
               if (req_side == SIDE_LOW && !low_empty) begin
                  low_count_in = low_count_ff - CW'(1);
               end else if (req_side == SIDE_HIGH && !high_empty) begin
                  high_count_in = high_count_ff - CW'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status_in     = status_ff;
      popped_in     = popped_ff;
      low_top_in    = low_top_ff;
      low_valid_in  = low_valid_ff;
      high_top_in   = high_top_ff;
      high_valid_in = high_valid_ff;
      if (ctl.load_direct) begin
         popped_in     = '0;
         low_top_in    = '0;
         low_valid_in  = 1'b0;
         high_top_in   = '0;
         high_valid_in = 1'b0;
         case (req_cmd)
            CMD_PUSH: status_in = full ? STATUS_FULL : STATUS_OK;
            CMD_POP:  status_in = STATUS_EMPTY;
            CMD_PEEK: status_in = STATUS_EMPTY;
            default:  status_in = STATUS_OK;
         endcase
      end else if (ctl.load_mem) begin
         status_in     = STATUS_OK;
         popped_in     = '0;
         low_top_in    = '0;
         low_valid_in  = 1'b0;
         high_top_in   = '0;
         high_valid_in = 1'b0;
         if (pend_pop_ff) begin
            popped_in = (pend_side_ff == SIDE_LOW) ? rd_data_a : rd_data_b;
         end else begin
            low_valid_in  = pend_lval_ff;
            high_valid_in = pend_hval_ff;
            low_top_in    = pend_lval_ff ? rd_data_a : '0;
            high_top_in   = pend_hval_ff ? rd_data_b : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= '0;
         high_count_ff <= '0;
      end else begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         pend_pop_ff  <= (req_cmd == CMD_POP);
         pend_side_ff <= req_side;
         pend_lval_ff <= !low_empty;
         pend_hval_ff <= !high_empty;
      end
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      low_top_ff    <= low_top_in;
      low_valid_ff  <= low_valid_in;
      high_top_ff   <= high_top_in;
      high_valid_ff <= high_valid_in;
   end

   assign rsp_status     = status_ff;
   assign rsp_popped     = popped_ff;
   assign rsp_low_top    = low_top_ff;
   assign rsp_low_valid  = low_valid_ff;
   assign rsp_high_top   = high_top_ff;
   assign rsp_high_valid = high_valid_ff;

   sdsk_ram #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_value),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

endmodule

FILE: tb/shared_array_dual_stack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shared_array_dual_stack_tb
// Self-checking bench for the two-stacks-in-one-array block. A short directed
// run covers empty pops and peeks, one-sided peeks, the unused command and
// extreme words. Random segments then alternate between filling, draining and
// mixed traffic, with random idling on both channels. A scoreboard predicts
// every response from its own copy of the stacks.
// ----------------------------------------------------------------------------
module shared_array_dual_stack_tb;
   import sdsk_pkg::*;

   localparam int STACK_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int CALM_ITEMS    = 250;
   localparam int STALL_LIMIT   = 2000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      word_type            popped;
      word_type            low_top;
      logic                low_valid;
      word_type            high_top;
      logic                high_valid;
   } stack_rsp_type;

   class stack_scoreboard_type;
      word_type      words[STACK_DEPTH];
      int            low_cnt;
      int            high_cnt;
      stack_rsp_type rsp_q[$];
      int            mismatches;
      int            checked;
      int            n_full;
      int            n_empty;
      int            n_popped;

      function new();
         low_cnt    = 0;
         high_cnt   = 0;
         mismatches = 0;
         checked    = 0;
         n_full     = 0;
         n_empty    = 0;
         n_popped   = 0;
      endfunction

      // Applies one accepted command to the stack copy and queues its response.
      function void note_request(logic [CMD_W-1:0] cmd, logic side, word_type value);
         stack_rsp_type r;
         r = '0;
         r.status = STATUS_OK;
         case (cmd)
            CMD_PUSH: begin
               if (low_cnt + high_cnt >= STACK_DEPTH) begin
                  r.status = STATUS_FULL;
               end else if (side == SIDE_LOW) begin
                  words[low_cnt] = value;
                  low_cnt++;
               end else begin
                  words[STACK_DEPTH - 1 - high_cnt] = value;
                  high_cnt++;
               end
            end
            CMD_POP: begin
               if (side == SIDE_LOW) begin
                  if (low_cnt == 0) begin
                     r.status = STATUS_EMPTY;
                  end else begin
                     low_cnt--;
                     r.popped = words[low_cnt];
                  end
               end else begin
                  if (high_cnt == 0) begin
                     r.status = STATUS_EMPTY;
                  end else begin
                     high_cnt--;
                     r.popped = words[STACK_DEPTH - 1 - high_cnt];
                  end
               end
            end
            CMD_PEEK: begin
               if (low_cnt != 0) begin
                  r.low_valid = 1'b1;
                  r.low_top   = words[low_cnt - 1];
               end
               if (high_cnt != 0) begin
                  r.high_valid = 1'b1;
                  r.high_top   = words[STACK_DEPTH - high_cnt];
               end
               if (low_cnt == 0 && high_cnt == 0) r.status = STATUS_EMPTY;
            end
            default: begin
            end
         endcase
         if (r.status == STATUS_FULL) n_full++;
         if (r.status == STATUS_EMPTY) n_empty++;
         if (cmd == CMD_POP && r.status == STATUS_OK) n_popped++;
         rsp_q.push_back(r);
      endfunction

      function void check_response(stack_rsp_type got);
         stack_rsp_type e;
         checked++;
         if (rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with nothing expected: %p", $realtime, got);
            return;
         end
         e = rsp_q.pop_front();
         if (got.status !== e.status || got.popped !== e.popped ||
             got.low_top !== e.low_top || got.low_valid !== e.low_valid ||
             got.high_top !== e.high_top || got.high_valid !== e.high_valid) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: response mismatch", $realtime);
               $display("   expected status=%0d popped=%h low=%h/%b high=%h/%b",
                        e.status, e.popped, e.low_top, e.low_valid,
                        e.high_top, e.high_valid);
               $display("   actual   status=%0d popped=%h low=%h/%b high=%h/%b",
                        got.status, got.popped, got.low_top, got.low_valid,
                        got.high_top, got.high_valid);
            end
         end
      endfunction

      function int pending();
         return rsp_q.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd;
   logic                     req_side;
   logic signed [WORD_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [WORD_W-1:0] rsp_popped;
   logic signed [WORD_W-1:0] rsp_low_top;
   logic                     rsp_low_valid;
   logic signed [WORD_W-1:0] rsp_high_top;
   logic                     rsp_high_valid;

   stack_scoreboard_type sb = new();
   bit                   sender_gaps;
   bit                   receiver_stalls;
   int                   items_sent;
   int                   quiet_cycles;
   int                   stall_left;

   shared_array_dual_stack #(.DEPTH(STACK_DEPTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_side       (req_side),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_popped     (rsp_popped),
      .rsp_low_top    (rsp_low_top),
      .rsp_low_valid  (rsp_low_valid),
      .rsp_high_top   (rsp_high_top),
      .rsp_high_valid (rsp_high_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Called at a falling edge; returns at the falling edge after the beat is
   // taken, with valid still high so that back-to-back commands need no gap.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic side,
                           input word_type value);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd   = cmd;
      req_side  = side;
      req_value = value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, side, value);
      items_sent++;
      @(negedge clock);
   endtask

   // Receiver: ready drops in random bursts while stalls are enabled.
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 18) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(stack_rsp_type'{rsp_status, rsp_popped, rsp_low_top,
                                           rsp_low_valid, rsp_high_top,
                                           rsp_high_valid});
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               n_random;
      int               seg_len;
      int               push_pct;
      int               pop_pct;
      int               roll;
      logic [CMD_W-1:0] cmd;
      word_type         value;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_PUSH;
      req_side        = SIDE_LOW;
      req_value       = '0;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      items_sent      = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty cases, the unused code, one-sided peeks, extreme words.
      send_cmd(CMD_PEEK, SIDE_LOW, 32'h1234_5678);
      send_cmd(CMD_POP, SIDE_LOW, '0);
      send_cmd(CMD_POP, SIDE_HIGH, 32'hFFFF_FFFF);
      send_cmd(CMD_UNUSED, SIDE_HIGH, 32'hDEAD_BEEF);
      send_cmd(CMD_PUSH, SIDE_LOW, 32'h7FFF_FFFF);
      send_cmd(CMD_PUSH, SIDE_HIGH, 32'h8000_0000);
      send_cmd(CMD_PEEK, SIDE_HIGH, '0);
      send_cmd(CMD_POP, SIDE_HIGH, '0);
      send_cmd(CMD_PEEK, SIDE_LOW, '0);
      send_cmd(CMD_POP, SIDE_HIGH, '0);
      send_cmd(CMD_POP, SIDE_LOW, '0);
      send_cmd(CMD_PEEK, SIDE_LOW, '0);
      send_cmd(CMD_PUSH, SIDE_HIGH, 32'hFFFF_FFFF);
      send_cmd(CMD_PEEK, SIDE_LOW, '0);
      send_cmd(CMD_PUSH, SIDE_LOW, 32'h0000_0000);
      send_cmd(CMD_UNUSED, SIDE_LOW, '0);
      send_cmd(CMD_PEEK, SIDE_HIGH, '0);
      send_cmd(CMD_POP, SIDE_LOW, '0);
      send_cmd(CMD_POP, SIDE_HIGH, '0);

      // Random segments: fill-heavy ones run into full, drain-heavy ones into
      // empty, and mixed ones move the meeting point back and forth.
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: begin
               push_pct = 70;
               pop_pct  = 15;
            end
            1: begin
               push_pct = 15;
               pop_pct  = 65;
            end
            default: begin
               push_pct = 40;
               pop_pct  = 35;
            end
         endcase
         seg_len = $urandom_range(16, 64);
         if (n_random < RANDOM_ITEMS - CALM_ITEMS) begin
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
         end else begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         for (int i = 0; i < seg_len && n_random < RANDOM_ITEMS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) cmd = CMD_PUSH;
            else if (roll < push_pct + pop_pct) cmd = CMD_POP;
            else if (roll < 97) cmd = CMD_PEEK;
            else cmd = CMD_UNUSED;
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = 32'hFFFF_FFFF;
                  default: value = 32'h0000_0000;
               endcase
            end else begin
               value = $urandom;
            end
            send_cmd(cmd, 1'($urandom_range(0, 1)), value);
            n_random++;
         end
      end
      req_valid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      $display("Sent %0d commands and checked %0d responses with random idling.",
               items_sent, sb.checked);
      $display("Saw %0d pushes refused as full, %0d empty pops or peeks, %0d words popped.",
               sb.n_full, sb.n_empty, sb.n_popped);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("Mismatches: %0d, responses still missing: %0d",
                  sb.mismatches, sb.pending());
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/sdsk_pkg.sv
sv/sdsk_ram.sv
sv/sdsk_ctrl.sv
sv/sdsk_dpath.sv
sv/shared_array_dual_stack.sv
tb/shared_array_dual_stack_tb.sv
